/* src/pvs_pkg.sv */
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared types and constants of the page victim selector: transaction
// payloads, policy and function codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pvs_pkg;

  // default table geometry
  localparam int unsigned NUM_FRAMES_DEF = 1024;
  localparam int unsigned AGE_BITS_DEF   = 32;

  // field widths fixed by the interface
  localparam int unsigned FRAME_W = 10;
  localparam int unsigned AGE_W   = 32;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned POL_W   = 2;

  // function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  // policy register codes
  localparam logic [POL_W-1:0] POLICY_RANDOM = 2'd0;
  localparam logic [POL_W-1:0] POLICY_AGING  = 2'd1;
  localparam logic [POL_W-1:0] POLICY_SECOND = 2'd2;

  // input transaction payload
  typedef struct packed {
    logic               func;
    logic [FRAME_W-1:0] frame;
    logic               in_use;
    logic               swappable;
    logic [AGE_W-1:0]   age;
    logic               chance_bit;
    logic [SEED_W-1:0]  seed;
  } pvs_in_t;

  // output transaction payload
  typedef struct packed {
    logic [FRAME_W-1:0] victim;
    logic               none_eligible;
  } pvs_out_t;

  // kind of table scan in progress
  typedef enum logic [1:0] {
    SCAN_RANDOM = 2'd0,
    SCAN_AGING  = 2'd1,
    SCAN_SECOND = 2'd2
  } pvs_scan_e;

  // controller to datapath
  typedef struct packed {
    logic      clear_run;
    logic      wr_en;
    logic      mod_start;
    logic      scan_start;
    logic      from_seed;
    logic      scan_run;
    pvs_scan_e mode;
    logic      load_result;
  } pvs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic mod_done;
    logic hit;
    logic scan_end;
    logic seen;
    logic out_free;
  } pvs_status_t;

endpackage

/* src/pvs_seed_mod.sv */
// ----------------------------------------------------------------------------
// pvs_seed_mod
// Reduces the random seed modulo the frame count by reciprocal
// multiplication: quotient estimate, back-multiply, one correction step.
// ----------------------------------------------------------------------------
module pvs_seed_mod #(
  parameter int unsigned NUM_FRAMES = pvs_pkg::NUM_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pvs_pkg::SEED_W-1:0]    seed_i,
  output logic                          done_o,
  output logic [$clog2(NUM_FRAMES)-1:0] rem_o
);
  import pvs_pkg::*;

  localparam int unsigned IDX_W  = $clog2(NUM_FRAMES);
  localparam int unsigned PROD_W = 2 * SEED_W;
  // floor(2^32 / frames): the quotient estimate is low by at most one
  localparam logic [SEED_W-1:0] RECIP =
    SEED_W'((64'd1 << SEED_W) / 64'(NUM_FRAMES));
  localparam logic [SEED_W-1:0] FRAMES_S = SEED_W'(NUM_FRAMES);
  localparam logic [1:0]        STEPS    = 2'd3;

  logic [SEED_W-1:0] seed_q, seed_d;
  logic [SEED_W-1:0] quot_q, quot_d;
  logic [SEED_W-1:0] part_q, part_d;
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [1:0]        step_q, step_d;
  logic [PROD_W-1:0] prod;

  // quotient estimate
  assign prod = PROD_W'(seed_q) * PROD_W'(RECIP);

  // three stages run each step, each working on the registered result of the one before
  always_comb begin
    seed_d = seed_q;
    quot_d = quot_q;
    part_d = part_q;
    rem_d  = rem_q;
    step_d = step_q;
    if (start_i) begin
      seed_d = seed_i;
      step_d = STEPS;
    end else if (step_q != '0) begin
      quot_d = prod[PROD_W-1:SEED_W];
      part_d = seed_q - SEED_W'(quot_q * FRAMES_S);
      if (part_q >= FRAMES_S) begin
        rem_d = IDX_W'(part_q - FRAMES_S);
      end else begin
        rem_d = IDX_W'(part_q);
      end
      step_d = step_q - 1'b1;
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  // pipeline registers
  always_ff @(posedge clk_i) begin
    seed_q <= seed_d;
    quot_q <= quot_d;
    part_q <= part_d;
    rem_q  <= rem_d;
  end

  assign done_o = (step_q == '0);
  assign rem_o  = rem_q;

endmodule

/* src/pvs_datapath.sv */
// ----------------------------------------------------------------------------
// pvs_datapath
// Frame table memory, scan address and probe counters, victim tracking,
// seed reduction and the output register.
// ----------------------------------------------------------------------------
module pvs_datapath #(
  parameter int unsigned NUM_FRAMES = pvs_pkg::NUM_FRAMES_DEF,
  parameter int unsigned AGE_BITS   = pvs_pkg::AGE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pvs_pkg::pvs_cmd_t    cmd_i,
  output pvs_pkg::pvs_status_t status_o,
  input  pvs_pkg::pvs_in_t     in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pvs_pkg::pvs_out_t    out_data_o
);
  import pvs_pkg::*;

  localparam int unsigned IDX_W  = $clog2(NUM_FRAMES);
  localparam int unsigned CNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int unsigned WIDE_W = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;
  localparam int unsigned ENT_W  = AGE_BITS + 3;
  localparam int unsigned B_USE  = AGE_BITS + 2;
  localparam int unsigned B_SWAP = AGE_BITS + 1;
  localparam int unsigned B_CHN  = AGE_BITS;

  // frame table: {in_use, swappable, chance, age}
  logic [ENT_W-1:0] mem_q [NUM_FRAMES];

  logic [IDX_W-1:0]    addr_q, addr_d, addr_inc;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                rd_vld_q;
  logic [ENT_W-1:0]    rd_q;
  logic [IDX_W-1:0]    rd_idx_q;
  logic [IDX_W-1:0]    best_q;
  logic [AGE_BITS-1:0] best_age_q;
  logic                found_q, seen_q;
  logic                out_valid_q;
  pvs_out_t            out_data_q;

  logic                issue, eval, elig, hit, better, sc_clear;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENT_W-1:0]    mem_wdata;
  logic [WIDE_W-1:0]   frame_wide, victim_wide;
  logic                frame_ok;
  logic                mod_done;
  logic [IDX_W-1:0]    mod_rem;

  // seed reduction unit
  pvs_seed_mod #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_seed_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mod_start),
    .seed_i (in_data_i.seed),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  // wrap-around address step
  assign addr_inc = (addr_q == IDX_W'(NUM_FRAMES - 1)) ? '0 : addr_q + 1'b1;

  // scan evaluation of the entry read last cycle
  assign issue    = cmd_i.scan_run && (cnt_q != CNT_W'(NUM_FRAMES));
  assign eval     = cmd_i.scan_run && rd_vld_q;
  assign elig     = rd_q[B_USE] && rd_q[B_SWAP];
  assign hit      = eval && elig && (cmd_i.mode != SCAN_AGING) &&
                    ((cmd_i.mode == SCAN_RANDOM) || !rd_q[B_CHN]);
  assign better   = eval && elig && (cmd_i.mode == SCAN_AGING) &&
                    (!found_q || (rd_q[AGE_BITS-1:0] < best_age_q));
  assign sc_clear = eval && elig && (cmd_i.mode == SCAN_SECOND) && rd_q[B_CHN];

  // write range check
  assign frame_wide = WIDE_W'(in_data_i.frame);
  assign frame_ok   = frame_wide < WIDE_W'(NUM_FRAMES);

  // memory write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    if (cmd_i.clear_run) begin
      mem_we = 1'b1;
    end else if (cmd_i.wr_en) begin
      mem_we    = frame_ok;
      mem_waddr = IDX_W'(frame_wide);
      mem_wdata = {in_data_i.in_use, in_data_i.swappable, in_data_i.chance_bit,
                   AGE_BITS'(in_data_i.age)};
    end else if (sc_clear) begin
      mem_we            = 1'b1;
      mem_waddr         = rd_idx_q;
      mem_wdata         = rd_q;
      mem_wdata[B_CHN]  = 1'b0;
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_q     <= mem_q[addr_q];
      rd_idx_q <= addr_q;
    end
  end

  // address and probe counters
  always_comb begin
    addr_d = addr_q;
    cnt_d  = cnt_q;
    if (cmd_i.scan_start) begin
      addr_d = cmd_i.from_seed ? mod_rem : '0;
      cnt_d  = '0;
    end else if (cmd_i.clear_run || issue) begin
      addr_d = addr_inc;
      cnt_d  = issue ? cnt_q + 1'b1 : cnt_q;
    end
  end

  // scan control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      seen_q   <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= issue && !cmd_i.scan_start;
      if (cmd_i.scan_start) begin
        found_q <= 1'b0;
        seen_q  <= 1'b0;
      end else begin
        if (hit || better) begin
          found_q <= 1'b1;
        end
        if (eval && elig) begin
          seen_q <= 1'b1;
        end
      end
    end
  end

  // best candidate so far
  always_ff @(posedge clk_i) begin
    if (hit || better) begin
      best_q     <= rd_idx_q;
      best_age_q <= rd_q[AGE_BITS-1:0];
    end
  end

  // output register
  assign victim_wide = WIDE_W'(best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      out_data_q.victim        <= found_q ? victim_wide[FRAME_W-1:0] : '0;
      out_data_q.none_eligible <= !found_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // status back to the controller
  assign status_o.clear_last = cmd_i.clear_run && (addr_q == IDX_W'(NUM_FRAMES - 1));
  assign status_o.mod_done   = mod_done;
  assign status_o.hit        = hit;
  assign status_o.scan_end   = (cnt_q == CNT_W'(NUM_FRAMES)) && !rd_vld_q;
  assign status_o.seen       = seen_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

/* src/pvs_ctrl.sv */
// ----------------------------------------------------------------------------
// pvs_ctrl
// Sequencer of the page victim selector: clearing pass, transaction
// intake, seed reduction, table scans per policy and result hand-off.
// ----------------------------------------------------------------------------
module pvs_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_func_i,
  output logic                        in_ready_o,
  input  logic                        cfg_valid_i,
  input  logic [pvs_pkg::POL_W-1:0]   cfg_data_i,
  output pvs_pkg::pvs_cmd_t           cmd_o,
  input  pvs_pkg::pvs_status_t        status_i
);
  import pvs_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_MOD    = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_RESULT = 5'b10000
  } pvs_state_e;

  pvs_state_e       state_q, state_d;
  pvs_scan_e        mode_q, mode_d, pol_mode;
  logic [POL_W-1:0] policy_q;
  logic             accept;

  // policy register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_RANDOM;
    end else if (cfg_valid_i) begin
      policy_q <= cfg_data_i;
    end
  end

  // scan kind for the configured policy, unused code acts as random
  always_comb begin
    case (policy_q)
      POLICY_AGING:  pol_mode = SCAN_AGING;
      POLICY_SECOND: pol_mode = SCAN_SECOND;
      default:       pol_mode = SCAN_RANDOM;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    cmd_o.mode = mode_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_run = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_func_i == FUNC_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.mod_start = 1'b1;
            state_d         = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (status_i.mod_done) begin
          cmd_o.scan_start = 1'b1;
          cmd_o.from_seed  = (pol_mode == SCAN_RANDOM);
          mode_d           = pol_mode;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.hit) begin
          state_d = ST_RESULT;
        end else if (status_i.scan_end) begin
          if (mode_q == SCAN_SECOND && status_i.seen) begin
            // every eligible frame had its bit set: fall back to random probe
            cmd_o.scan_run   = 1'b0;
            cmd_o.scan_start = 1'b1;
            cmd_o.from_seed  = 1'b1;
            mode_d           = SCAN_RANDOM;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      mode_q  <= SCAN_RANDOM;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

/* src/page_victim_selector_core.sv */
// ----------------------------------------------------------------------------
// page_victim_selector_core
// Frame table with victim selection by random probe, aging or second chance.
// ----------------------------------------------------------------------------
// After reset the block sweeps the frame table to zero, one entry per cycle,
// and takes no input transaction until the sweep is done (policy writes are
// taken throughout). A write transaction goes straight into the table. A
// select transaction first reduces the seed modulo NUM_FRAMES by reciprocal
// multiplication, then runs one table scan of up to NUM_FRAMES entries, in
// which the single read port of the table delivers one entry per cycle; a
// second-chance select that finds only referenced frames runs a second,
// random scan, and the result is loaded into the output register once that
// is free. One transaction is worked on at a time; a finished result sits
// in an output register while the next transaction is taken.
module page_victim_selector_core #(
  parameter int unsigned NUM_FRAMES = pvs_pkg::NUM_FRAMES_DEF,
  parameter int unsigned AGE_BITS   = pvs_pkg::AGE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pvs_pkg::pvs_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pvs_pkg::pvs_out_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pvs_pkg::POL_W-1:0] cfg_data_i
);
  import pvs_pkg::*;

  pvs_cmd_t    cmd;
  pvs_status_t status;

  // policy register is always writable
  assign cfg_ready_o = 1'b1;

  // controller
  pvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_data_i.func),
    .in_ready_o (in_ready_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // datapath
  pvs_datapath #(
    .NUM_FRAMES(NUM_FRAMES),
    .AGE_BITS  (AGE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
